>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the leaving-row selector.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold.
`define SLRS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SLRS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define SLRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/slrs_pkg.sv
// Shared constants and types of the simplex leaving-row selector.
// Used by the queue front end, the row engine and the top level.
`default_nettype none

package slrs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 31;
    localparam int MAX_COLS  = 64;
    localparam int COL_W     = 7;   // holds 0 .. MAX_COLS
    localparam int CIDX_W    = 6;   // column index inside one half of the store
    localparam int ROW_W     = 8;
    localparam int RAM_DEPTH = 2 * MAX_COLS;
    localparam int RAM_AW    = 7;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int DCNT_W    = 6;
    localparam int QDEPTH    = 2;
    localparam int PADDR_W   = 2;

    // Row verdict codes.
    localparam logic [1:0] V_NONE = 2'd0;
    localparam logic [1:0] V_TAKE = 2'd1;
    localparam logic [1:0] V_DROP = 2'd2;
    localparam logic [1:0] V_TIE  = 2'd3;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] ADDR_TOLERANCE = 2'd0;

    typedef struct packed {
        logic signed [DATA_W-1:0] basic_value;
        logic signed [DATA_W-1:0] direction_value;
        logic signed [DATA_W-1:0] coefficient;
        logic                     last;
        logic                     set_end;
    } item_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] fill;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/slrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module slrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/slrs_front.sv
// Front end: accepts input requests, marks the row end, and holds them in a
// two-entry queue for the row engine. Depends on slrs_pkg.
`default_nettype none

module slrs_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [31:0]         basic_value,
    input  wire logic signed [31:0]         direction_value,
    input  wire logic signed [31:0]         coefficient,
    input  wire logic                       row_end,
    input  wire logic                       set_end,
    output logic                            q_valid,
    output slrs_pkg::item_t                 q_item,
    input  wire logic                       q_pop,
    output logic [1:0]                      q_fill
);

    slrs_pkg::item_t ent_reg [slrs_pkg::QDEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    slrs_pkg::item_t new_item;

    assign in_stall = (count_reg == 2'(slrs_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign q_fill   = count_reg;

    always_comb
    begin
        new_item.basic_value     = basic_value;
        new_item.direction_value = direction_value;
        new_item.coefficient     = coefficient;
        // The set end also closes the row it falls in.
        new_item.last            = row_end || set_end;
        new_item.set_end         = set_end;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !(q_pop && q_valid))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop && q_valid)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slrs_back.sv
// Row engine: ratio divider, ratio verdict, lexicographic tie compare over
// the ping-pong row store, and the result register. Depends on slrs_pkg
// and slrs_ram.
`default_nettype none

module slrs_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [slrs_pkg::TOL_W-1:0]   tolerance,
    input  wire logic                         q_valid,
    input  wire slrs_pkg::item_t              q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic [7:0]                        leaving_row,
    output slrs_pkg::stat_t                   stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RAT  = 3'd2;
    localparam logic [2:0] S_VERD = 3'd3;
    localparam logic [2:0] S_ELEM = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]                          state_reg;
    slrs_pkg::item_t                     item_reg;
    logic [slrs_pkg::COL_W-1:0]          col_reg;
    logic [1:0]                          verdict_reg;
    logic signed [31:0]                  cur_ratio_reg;
    logic signed [31:0]                  cur_dir_reg;
    logic signed [31:0]                  best_ratio_reg;
    logic signed [31:0]                  best_dir_reg;
    logic [slrs_pkg::COL_W-1:0]          best_len_reg;
    logic [slrs_pkg::ROW_W-1:0]          best_idx_reg;
    logic                                have_best_reg;
    logic                                sel_reg;
    logic [slrs_pkg::ROW_W-1:0]          row_idx_reg;
    logic [31:0]                         rem_reg;
    logic [slrs_pkg::DIV_W-1:0]          quo_reg;
    logic [slrs_pkg::DCNT_W-1:0]         dcnt_reg;
    logic                                neg_reg;
    logic signed [63:0]                  lhs_reg;
    logic signed [63:0]                  rhs_reg;
    logic                                out_valid_reg;
    logic                                found_reg;
    logic [7:0]                          leaving_reg;

    logic                                ram_we;
    logic [slrs_pkg::RAM_AW-1:0]         ram_waddr;
    logic [slrs_pkg::RAM_AW-1:0]         ram_raddr;
    logic [31:0]                         ram_rdata;

    logic [32:0]                         rem_sh;
    logic                                rem_ge;
    logic signed [31:0]                  sat_ratio;
    logic signed [33:0]                  cr34;
    logic signed [33:0]                  br34;
    logic signed [33:0]                  tol34;
    logic signed [33:0]                  diff34;
    logic                                is_cand;
    logic [31:0]                         xb_mag;
    logic [slrs_pkg::COL_W-1:0]          col_inc;
    logic                                in_range;
    logic                                hold_out;
    logic                                res_load;

    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign leaving_row = leaving_reg;
    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.fill   = {1'b0, out_valid_reg};

    assign in_range = !col_reg[slrs_pkg::COL_W-1];
    assign col_inc  = in_range ? col_reg + slrs_pkg::COL_W'(1) : col_reg;
    assign hold_out = item_reg.set_end && out_valid_reg && out_stall;
    assign res_load = (state_reg == S_FIN) && item_reg.set_end && !hold_out;

    assign is_cand = $signed(q_item.direction_value) > $signed({1'b0, tolerance});
    assign xb_mag  = q_item.basic_value[31] ? 32'(-q_item.basic_value)
                                            : 32'(q_item.basic_value);

    // Current row goes into the spare half, the best row is read from the other.
    assign ram_we    = (state_reg == S_ELEM) && in_range && (verdict_reg != slrs_pkg::V_NONE);
    assign ram_waddr = {~sel_reg, col_reg[slrs_pkg::CIDX_W-1:0]};
    assign ram_raddr = {sel_reg, col_reg[slrs_pkg::CIDX_W-1:0]};

    slrs_ram #(
        .WIDTH(32),
        .DEPTH(slrs_pkg::RAM_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(item_reg.coefficient),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // One restoring division step per cycle on magnitudes.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[slrs_pkg::DIV_W-1]};
        rem_ge = rem_sh >= {1'b0, item_reg.direction_value};
    end

    // Truncated quotient, sign applied, saturated to 32 bits.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg > slrs_pkg::DIV_W'(32'h7FFF_FFFF))
                sat_ratio = 32'sh7FFF_FFFF;
            else
                sat_ratio = $signed(quo_reg[31:0]);
        end
        else
        begin
            if (quo_reg > slrs_pkg::DIV_W'(32'h8000_0000))
                sat_ratio = 32'sh8000_0000;
            else
                sat_ratio = $signed(32'(-quo_reg[31:0]));
        end
    end

    always_comb
    begin
        cr34   = 34'(cur_ratio_reg);
        br34   = 34'(best_ratio_reg);
        tol34  = $signed({3'b000, tolerance});
        diff34 = cr34 - br34;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            lhs_reg <= 64'(item_reg.coefficient) * 64'(best_dir_reg);
            rhs_reg <= 64'($signed(ram_rdata)) * 64'(cur_dir_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            col_reg        <= '0;
            verdict_reg    <= slrs_pkg::V_NONE;
            cur_ratio_reg  <= '0;
            cur_dir_reg    <= '0;
            best_ratio_reg <= '0;
            best_dir_reg   <= '0;
            best_len_reg   <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
            sel_reg        <= 1'b0;
            row_idx_reg    <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            dcnt_reg       <= '0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            leaving_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !res_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        if (col_reg == '0)
                        begin
                            cur_dir_reg   <= q_item.direction_value;
                            cur_ratio_reg <= '0;
                            verdict_reg   <= slrs_pkg::V_NONE;
                            if (is_cand)
                            begin
                                neg_reg   <= q_item.basic_value[31];
                                quo_reg   <= {xb_mag, {slrs_pkg::FRAC_BITS{1'b0}}};
                                rem_reg   <= '0;
                                dcnt_reg  <= '0;
                                state_reg <= S_DIV;
                            end
                            else
                            begin
                                state_reg <= S_ELEM;
                            end
                        end
                        else
                        begin
                            state_reg <= S_ELEM;
                        end
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? 32'(rem_sh - {1'b0, item_reg.direction_value})
                                       : rem_sh[31:0];
                    quo_reg  <= {quo_reg[slrs_pkg::DIV_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + slrs_pkg::DCNT_W'(1);
                    if (dcnt_reg == slrs_pkg::DCNT_W'(slrs_pkg::DIV_W - 1))
                    begin
                        state_reg <= S_RAT;
                    end
                end
                S_RAT:
                begin
                    cur_ratio_reg <= sat_ratio;
                    state_reg     <= S_VERD;
                end
                S_VERD:
                begin
                    if (!have_best_reg || (cr34 < br34 - tol34))
                        verdict_reg <= slrs_pkg::V_TAKE;
                    else if ((diff34 <= tol34) && (-diff34 <= tol34))
                        verdict_reg <= slrs_pkg::V_TIE;
                    else
                        verdict_reg <= slrs_pkg::V_DROP;
                    state_reg <= S_ELEM;
                end
                S_ELEM:
                begin
                    if (in_range && (verdict_reg == slrs_pkg::V_TIE) && (col_reg < best_len_reg))
                        state_reg <= S_RD;
                    else
                        state_reg <= S_FIN;
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (lhs_reg < rhs_reg)
                        verdict_reg <= slrs_pkg::V_TAKE;
                    else if (lhs_reg > rhs_reg)
                        verdict_reg <= slrs_pkg::V_DROP;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!hold_out)
                    begin
                        state_reg <= S_IDLE;
                        if (item_reg.last)
                        begin
                            col_reg     <= '0;
                            verdict_reg <= slrs_pkg::V_NONE;
                            if (verdict_reg == slrs_pkg::V_TAKE)
                            begin
                                sel_reg <= ~sel_reg;
                            end
                        end
                        else
                        begin
                            col_reg <= col_inc;
                        end
                        if (item_reg.set_end)
                        begin
                            out_valid_reg <= 1'b1;
                            if (verdict_reg == slrs_pkg::V_TAKE)
                            begin
                                found_reg   <= 1'b1;
                                leaving_reg <= row_idx_reg;
                            end
                            else
                            begin
                                found_reg   <= have_best_reg;
                                leaving_reg <= have_best_reg ? best_idx_reg : 8'd0;
                            end
                            have_best_reg  <= 1'b0;
                            best_idx_reg   <= '0;
                            best_ratio_reg <= '0;
                            best_dir_reg   <= '0;
                            best_len_reg   <= '0;
                            row_idx_reg    <= '0;
                            cur_ratio_reg  <= '0;
                            cur_dir_reg    <= '0;
                        end
                        else if (item_reg.last)
                        begin
                            row_idx_reg <= row_idx_reg + slrs_pkg::ROW_W'(1);
                            if (verdict_reg == slrs_pkg::V_TAKE)
                            begin
                                have_best_reg  <= 1'b1;
                                best_idx_reg   <= row_idx_reg;
                                best_ratio_reg <= cur_ratio_reg;
                                best_dir_reg   <= cur_dir_reg;
                                best_len_reg   <= col_inc;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/simplex_leaving_row_select.sv
// Simplex minimum-ratio test with a lexicographic tie-break.
// Requests are tableau elements, one per accepted request, rows in order;
// the first element of a row carries its basic value and direction entry.
// A result request (found, leaving_row) follows each element marked set_end.
// Front: a two-entry input queue. Back: a row engine with a 48-step serial
// divider, a 32x32 cross-product compare, and a 128-word ping-pong row store.
// Element steps in the engine: pop, element and finish; a tie compare that
// reads the store adds a read and a compare step, and the first element of a
// candidate row adds the 48 divide steps, saturation and verdict. The engine
// takes one element at a time; the queue absorbs the divider's gap for 2
// requests. With an idle engine, out_valid is set by the finish step of the
// set end, after the steps above. The input queue keeps accepting while a
// result waits, until it is full.
// A stalled result holds the engine on the next set end only.
// Reset clears all control state and sets the tolerance to 1; the row store
// needs no clearing. Tolerance is written over the APB port at address 0.
// Depends on slrs_pkg, slrs_front, slrs_back, slrs_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module simplex_leaving_row_select (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [slrs_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [31:0]                basic_value,
    input  wire logic signed [31:0]                direction_value,
    input  wire logic signed [31:0]                coefficient,
    input  wire logic                              row_end,
    input  wire logic                              set_end,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   found,
    output logic [7:0]                             leaving_row
);

    logic [slrs_pkg::TOL_W-1:0] tol_reg;
    logic                       q_valid;
    slrs_pkg::item_t            q_item;
    logic                       q_pop;
    logic [1:0]                 q_fill;
    slrs_pkg::stat_t            stat;

    assign pready = 1'b1;
    assign prdata = (paddr == slrs_pkg::ADDR_TOLERANCE) ? {1'b0, tol_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= slrs_pkg::TOL_W'(1);
        end
        else if (psel && penable && pwrite && pready && (paddr == slrs_pkg::ADDR_TOLERANCE))
        begin
            tol_reg <= pwdata[slrs_pkg::TOL_W-1:0];
        end
    end

    slrs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .basic_value    (basic_value),
        .direction_value(direction_value),
        .coefficient    (coefficient),
        .row_end        (row_end),
        .set_end        (set_end),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .q_fill         (q_fill)
    );

    slrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tolerance  (tol_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .leaving_row(leaving_row),
        .stat       (stat)
    );

    `SLRS_ASSERT_IMPLY(a_notfound_zero, out_valid && !found, leaving_row == 8'd0)
    `SLRS_ASSERT_NEVER(a_queue_overfill, q_fill > 2'(slrs_pkg::QDEPTH))
    `SLRS_ASSERT_NEXT(a_pop_busy, q_pop, stat.busy)
    `SLRS_ASSERT_NEVER(a_result_fill, stat.fill[1] || (stat.fill[0] != out_valid))

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for simplex_leaving_row_select (minimum-ratio row pick).
// Needs slrs_pkg and the RTL; a built-in predictor checks every result request.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int PLAN_LEN = 17;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [slrs_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] basic_value = '0, direction_value = '0, coefficient = '0;
    logic row_end = 1'b0, set_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [7:0] leaving_row;

    simplex_leaving_row_select u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic       found;
        logic [7:0] row;
    } pick_t;

    typedef struct {
        logic signed [31:0] xb, dv, cf;
        logic re, se;
        logic chk;      // typed-in expectation present
        pick_t want;
    } elem_t;

    // Predictor state.
    logic [30:0] tol_q;
    logic [31:0] store_q [2*slrs_pkg::MAX_COLS];
    logic have_best_q;
    logic [7:0] best_idx_q, cur_idx_q;
    longint best_ratio_q, best_dir_q, cur_ratio_q, cur_dir_q;
    int best_len_q, col_q;
    logic sel_q;
    logic [1:0] verdict_q;

    pick_t picks_due [$];
    int errors = 0;
    int idle_pct = 0, stall_pct = 0;
    int quiet = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void clear_set();
        have_best_q = 1'b0; best_idx_q = '0; best_ratio_q = 0; best_dir_q = 0;
        best_len_q = 0; cur_idx_q = '0; col_q = 0; cur_ratio_q = 0; cur_dir_q = 0;
        verdict_q = slrs_pkg::V_NONE;
    endfunction

    function automatic longint q16_ratio(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    // Advances the predictor by one element; returns 1 when a pick is produced.
    function automatic bit predict_pick(elem_t e, output pick_t p);
        longint tol, diff, lhs, rhs, cb;
        logic spare;
        bit last;
        tol = longint'(tol_q);
        spare = ~sel_q;
        last = e.re | e.se;
        if (col_q == 0)
        begin
            cur_dir_q = longint'(e.dv);
            cur_ratio_q = 0;
            verdict_q = slrs_pkg::V_NONE;
            if (longint'(e.dv) > tol)
            begin
                cur_ratio_q = q16_ratio(e.xb, e.dv);
                diff = cur_ratio_q - best_ratio_q;
                if (!have_best_q || cur_ratio_q < best_ratio_q - tol)
                    verdict_q = slrs_pkg::V_TAKE;
                else if (diff <= tol && -diff <= tol)
                    verdict_q = slrs_pkg::V_TIE;
                else
                    verdict_q = slrs_pkg::V_DROP;
            end
        end
        if (col_q < slrs_pkg::MAX_COLS)
        begin
            if (verdict_q != slrs_pkg::V_NONE)
                store_q[spare*slrs_pkg::MAX_COLS + col_q] = e.cf;
            if (verdict_q == slrs_pkg::V_TIE && col_q < best_len_q)
            begin
                cb = longint'($signed(store_q[sel_q*slrs_pkg::MAX_COLS + col_q]));
                lhs = longint'(e.cf) * best_dir_q;
                rhs = cb * cur_dir_q;
                if (lhs < rhs) verdict_q = slrs_pkg::V_TAKE;
                else if (lhs > rhs) verdict_q = slrs_pkg::V_DROP;
            end
            col_q++;
        end
        if (last)
        begin
            if (verdict_q == slrs_pkg::V_TAKE)
            begin
                have_best_q = 1'b1; best_idx_q = cur_idx_q; best_ratio_q = cur_ratio_q;
                best_dir_q = cur_dir_q; best_len_q = col_q; sel_q = spare;
            end
            col_q = 0;
            verdict_q = slrs_pkg::V_NONE;
            cur_idx_q = cur_idx_q + 8'd1;
        end
        if (e.se)
        begin
            p.found = have_best_q;
            p.row = have_best_q ? best_idx_q : 8'd0;
            clear_set();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic apb_write(input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = slrs_pkg::ADDR_TOLERANCE; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        tol_q = val[30:0];
    endtask

    // Holds the request until accepted; valid stays up until the next
    // request, an idle cycle, or settle lowers it.
    task automatic drive(input elem_t e);
        pick_t p;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        basic_value <= e.xb; direction_value <= e.dv; coefficient <= e.cf;
        row_end <= e.re; set_end <= e.se;
        do @(posedge clk); while (in_stall);
        if (predict_pick(e, p))
        begin
            if (e.chk && (p.found !== e.want.found || p.row !== e.want.row))
                report("predictor disagrees with directed row");
            picks_due.insert(picks_due.size(), p);
        end
        @(negedge clk);
    endtask

    // Waits until all picks are in, then lets the engine drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (picks_due.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // Receiver side: stall and check.
    always @(negedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (out_valid && !out_stall)
            begin
                if (picks_due.size() == 0)
                    report("result request with nothing expected");
                else
                begin
                    pick_t w;
                    w = picks_due.pop_front();
                    if (found !== w.found)
                        report($sformatf("found %0b, expected %0b", found, w.found));
                    if (leaving_row !== w.row)
                        report($sformatf("leaving_row %0d, expected %0d", leaving_row, w.row));
                end
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic elem_t mk(longint xb, longint dv, longint cf, bit re, bit se);
        elem_t e;
        e.xb = 32'(xb); e.dv = 32'(dv); e.cf = 32'(cf); e.re = re; e.se = se;
        e.chk = 1'b0; e.want.found = 1'b0; e.want.row = '0;
        return e;
    endfunction

    function automatic elem_t mkx(longint xb, longint dv, longint cf, bit re, bit se,
                                  bit f, int r);
        elem_t e;
        e = mk(xb, dv, cf, re, se);
        e.chk = 1'b1; e.want.found = f; e.want.row = 8'(r);
        return e;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(3);
            3: return -$urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // One set with random content, at times with a row end dropped; values often
    // come from a small pool so that ratio ties and tied coefficient prefixes occur.
    task automatic random_set(output int n);
        int rows, len;
        logic signed [31:0] xb, dv, cf;
        elem_t e;
        bit broken;
        n = 0;
        rows = $urandom_range(1, 6);
        if ($urandom_range(40) == 0) rows = $urandom_range(60, 90);
        for (int r = 0; r < rows; r++)
        begin
            len = $urandom_range(1, 5);
            if ($urandom_range(60) == 0) len = $urandom_range(64, 70);
            broken = ($urandom_range(9) == 0);
            if ($urandom_range(2) == 0)
            begin
                xb = $urandom_range(4) << 16;
                dv = $urandom_range(3) << 16;
            end
            else
            begin
                xb = rnd_word();
                dv = rnd_word();
            end
            for (int c = 0; c < len; c++)
            begin
                cf = ($urandom_range(1) != 0) ? ($urandom_range(3) << 15) : rnd_word();
                e = mk($urandom, $urandom, cf, c == len-1, 1'b0);
                if (c == 0)
                begin
                    e.xb = xb; e.dv = dv;
                end
                if (broken && c == len-1 && $urandom_range(1)) e.re = 1'b0;
                if (r == rows-1 && c == len-1) e.se = 1'b1;
                drive(e);
                n++;
            end
        end
    endtask

    elem_t plan [PLAN_LEN];

    initial
    begin
        int count, n;
        tol_q = 31'd1;
        sel_q = 1'b0;
        clear_set();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: unbounded set, single candidate, ties, extremes.
        plan[0]  = mkx(32'h10000, 0, 5, 1, 1, 0, 0);
        plan[1]  = mkx(32'h10000, 32'h10000, 5, 1, 1, 1, 0);
        plan[2]  = mk(32'h20000, 32'h10000, 1, 1, 0);
        plan[3]  = mkx(32'h10000, 32'h10000, 1, 1, 1, 1, 1);
        plan[4]  = mk(32'h10000, 32'h10000, 3, 0, 0);
        plan[5]  = mk(0, 0, 4, 1, 0);
        plan[6]  = mk(32'h10000, 32'h10000, 3, 0, 0);
        plan[7]  = mk(0, 0, 2, 1, 0);
        plan[8]  = mk(32'h10000, 32'h10000, 3, 0, 0);
        plan[9]  = mkx(0, 0, 2, 0, 1, 1, 1);
        plan[10] = mk(32'h7FFFFFFF, 1, 32'h80000000, 1, 0);
        plan[11] = mk(32'h80000000, 2, 32'h7FFFFFFF, 1, 0);
        plan[12] = mk(32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 0);
        plan[13] = mk(32'h80000000, 32'h80000000, 0, 1, 1);
        plan[14] = mk(5, 32'h30000, 7, 0, 0);
        plan[15] = mk(0, 0, 7, 1, 0);
        plan[16] = mk(5, 32'h30000, 7, 1, 1);
        foreach (plan[i]) drive(plan[i]);

        // Sweep settings and handshake phases.
        count = PLAN_LEN;
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph % 4)
                0: apb_write(32'h7FFFFFFF);
                1: apb_write(32'd0);
                2: apb_write(32'h00001000);
                default: apb_write(32'd1);
            endcase
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 45; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 45; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            while (count < 1400 * (ph + 1) / 8)
            begin
                random_set(n);
                count += n;
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/slrs_pkg.sv
rtl/core/slrs_ram.sv
rtl/core/slrs_front.sv
rtl/core/slrs_back.sv
rtl/core/simplex_leaving_row_select.sv
tb/tb.sv
